### sv/mds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mds_pkg
// shared sizes, types and register indexes of the diagonal matrix sorter
// ----------------------------------------------------------------------------
package mds_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int DATA_WIDTH  = 32;

  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int MAX_DIM     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);

  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 1;
  localparam int VALUE_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 4'd8;
  localparam logic [CFG_W-1:0] COL_COUNT_RESET = 4'd8;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

endpackage

### sv/matrix_diagonal_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_diagonal_sorter_top
// loads a matrix row-major, sorts every top-left to bottom-right diagonal
// ascending with one shared compare-exchange unit, then emits it row-major
// ----------------------------------------------------------------------------
// sorting: one shared compare-exchange unit, each pair passes through the read,
//   compare and write states
// throughput: one input per cycle while loading, input stalled while sorting/emitting;
//   each output passes through the emit read and emit load states
// reset: synchronous, clears control state; row/col counts return to 8,
//   matrix store contents stay undefined until written
module matrix_diagonal_sorter_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [mds_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mds_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [31:0]                  element_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [31:0]                  sorted_value,
  output logic                                last_element
);
  import mds_pkg::*;

  // sequencer states
  localparam logic [2:0] S_LOAD     = 3'd0;
  localparam logic [2:0] S_SORT_RD  = 3'd1;
  localparam logic [2:0] S_SORT_CMP = 3'd2;
  localparam logic [2:0] S_SORT_WR  = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_LD  = 3'd5;

  logic [2:0]        state;
  logic [CFG_W-1:0]  row_count;
  logic [CFG_W-1:0]  col_count;
  logic [CNT_W-1:0]  load_count;
  logic [CNT_W-1:0]  emit_index;
  logic [DIM_W-1:0]  pass;
  logic [DIM_W-1:0]  row;
  logic [DIM_W-1:0]  col;
  logic [ADDR_W-1:0] pair_addr;
  data_t             high_value;

  // matrix store: one write port, two registered read ports
  data_t             store [STORE_DEPTH];
  data_t             rd_data0;
  data_t             rd_data1;
  logic [ADDR_W-1:0] rd_addr0;
  logic [ADDR_W-1:0] rd_addr1;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  data_t             wr_data;

  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  cols;
  logic [DIM_W-1:0]  diag_len;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  load_count_next;
  logic [ADDR_W-1:0] partner_addr;
  logic              in_accept;
  logic              out_free;
  logic              emit_last;

  // dimensions in use: zero reads as one, oversize saturates
  always_comb begin
    if (row_count == '0) begin
      rows = DIM_W'(1);
    end else if (32'(row_count) > MAX_ROWS) begin
      rows = DIM_W'(MAX_ROWS);
    end else begin
      rows = DIM_W'(row_count);
    end
    if (col_count == '0) begin
      cols = DIM_W'(1);
    end else if (32'(col_count) > MAX_COLS) begin
      cols = DIM_W'(MAX_COLS);
    end else begin
      cols = DIM_W'(col_count);
    end
  end

  assign diag_len        = (rows < cols) ? rows : cols;
  assign total           = CNT_W'(rows) * CNT_W'(cols);
  assign load_count_next = load_count + CNT_W'(1);

  // lower-right neighbor of the current pair's upper-left element
  assign partner_addr = pair_addr + ADDR_W'(cols) + ADDR_W'(1);

  assign in_stall  = (state != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign emit_last = (emit_index == total - CNT_W'(1));

  // store port selection
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = load_count[ADDR_W-1:0];
    wr_data  = DATA_WIDTH'(element_value);
    rd_addr0 = pair_addr;
    rd_addr1 = partner_addr;
    unique case (state)
      S_LOAD: begin
        wr_en = in_accept;
      end
      S_SORT_CMP: begin
        // smaller value goes to the upper-left end
        wr_en   = 1'b1;
        wr_addr = pair_addr;
        wr_data = (rd_data0 > rd_data1) ? rd_data1 : rd_data0;
      end
      S_SORT_WR: begin
        wr_en   = 1'b1;
        wr_addr = partner_addr;
        wr_data = high_value;
      end
      S_EMIT_RD: begin
        rd_addr0 = emit_index[ADDR_W-1:0];
      end
      S_EMIT_LD: begin
        // keep the read data in place while the output register is stalled
        rd_addr0 = emit_index[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    rd_data0 <= store[rd_addr0];
    rd_data1 <= store[rd_addr1];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= ROW_COUNT_RESET;
      col_count <= COL_COUNT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count <= cfg_data;
        REG_COL_COUNT: col_count <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      load_count <= '0;
      emit_index <= '0;
      pass       <= '0;
      row        <= '0;
      col        <= '0;
      pair_addr  <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_accept) begin
            if (load_count_next >= total) begin
              // matrix complete, sort only if any diagonal is longer than one
              load_count <= '0;
              pass       <= '0;
              row        <= '0;
              col        <= '0;
              pair_addr  <= '0;
              emit_index <= '0;
              state      <= (diag_len > DIM_W'(1)) ? S_SORT_RD : S_EMIT_RD;
            end else begin
              load_count <= load_count_next;
            end
          end
        end
        S_SORT_RD: begin
          state <= S_SORT_CMP;
        end
        S_SORT_CMP: begin
          state <= S_SORT_WR;
        end
        S_SORT_WR: begin
          state <= S_SORT_RD;
          if (col == cols - DIM_W'(2)) begin
            col <= '0;
            if (row == rows - DIM_W'(2)) begin
              // end of one bubble pass over all diagonals
              row       <= '0;
              pair_addr <= '0;
              if (pass == diag_len - DIM_W'(2)) begin
                emit_index <= '0;
                state      <= S_EMIT_RD;
              end else begin
                pass <= pass + DIM_W'(1);
              end
            end else begin
              row       <= row + DIM_W'(1);
              pair_addr <= pair_addr + ADDR_W'(2);
            end
          end else begin
            col       <= col + DIM_W'(1);
            pair_addr <= pair_addr + ADDR_W'(1);
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          if (out_free) begin
            if (emit_last) begin
              state <= S_LOAD;
            end else begin
              emit_index <= emit_index + CNT_W'(1);
              state      <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // larger value of the pair, held for the write-back state
  always_ff @(posedge clk) begin
    if (state == S_SORT_CMP) begin
      high_value <= (rd_data0 > rd_data1) ? rd_data0 : rd_data1;
    end
  end

  // output register, parts the result side from the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT_LD && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT_LD && out_free) begin
      sorted_value <= VALUE_W'(rd_data0);
      last_element <= emit_last;
    end
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the diagonal matrix sorter: matrices go in
// row-major, a shadow copy of the store sorts each diagonal on the last
// element, and every output transaction is checked against that order
// ----------------------------------------------------------------------------
module tb_top;
  import mds_pkg::*;

  // one output transaction as the bench expects it
  typedef struct {
    data_t value;
    logic  last;
  } matrix_out_t;

  localparam data_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam data_t VAL_MIN = 32'sh8000_0000;
  localparam int    HOLD_CYCLES = 300;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_COUNT;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic signed [31:0]   element_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [31:0]   sorted_value;
  logic                 last_element;

  // elements waiting to be offered, and sorted values still owed by the block
  data_t       element_q[$];
  matrix_out_t sorted_q[$];

  // shadow copy of the block's store, fill level and dimension registers
  data_t       shadow_mat [STORE_DEPTH];
  int          shadow_fill = 0;
  logic [3:0]  shadow_rows_cfg = ROW_COUNT_RESET;
  logic [3:0]  shadow_cols_cfg = COL_COUNT_RESET;

  int          errors = 0;
  int          queued = 0;      // input transactions handed to the driver so far
  int          idle_pct = 18;   // chance in percent that a side idles
  int          hold_req = 0;    // bumped by the stimulus to ask for a long hold-off
  int          hold_seen = 0;
  int          hold_left = 0;

  matrix_diagonal_sorter_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_value  (sorted_value),
    .last_element  (last_element)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // register value to dimension in use: zero reads as one, oversize saturates
  function automatic int bounded_dim(logic [3:0] v, int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  // ascending insertion sort of the diagonal that starts at (r0, c0)
  function automatic void sort_diagonal(int r0, int c0, int nr, int nc);
    data_t run [MAX_DIM];
    data_t v;
    int    len;
    int    j;
    len = 0;
    while (r0 + len < nr && c0 + len < nc) begin
      run[len] = shadow_mat[(r0 + len) * nc + c0 + len];
      len++;
    end
    for (int i = 1; i < len; i++) begin
      v = run[i];
      j = i;
      while (j > 0 && run[j-1] > v) begin
        run[j] = run[j-1];
        j--;
      end
      run[j] = v;
    end
    for (int i = 0; i < len; i++)
      shadow_mat[(r0 + i) * nc + c0 + i] = run[i];
  endfunction

  // store one accepted element; on the matrix's last one, sort and owe the output
  function automatic void load_element(data_t v);
    int          nr;
    int          nc;
    int          total;
    matrix_out_t entry;
    nr = bounded_dim(shadow_rows_cfg, MAX_ROWS);
    nc = bounded_dim(shadow_cols_cfg, MAX_COLS);
    total = nr * nc;
    if (shadow_fill < STORE_DEPTH) shadow_mat[shadow_fill] = v;
    shadow_fill++;
    // a shrink while loading makes the count already reached, so this completes
    if (shadow_fill < total) return;
    for (int d = 0; d < nc; d++) sort_diagonal(0, d, nr, nc);
    for (int d = 1; d < nr; d++) sort_diagonal(d, 0, nr, nc);
    for (int k = 0; k < total; k++) begin
      entry.value = shadow_mat[k];
      entry.last  = (k == total - 1);
      sorted_q = {sorted_q, entry};
    end
    shadow_fill = 0;
  endfunction

  // mix of full-range values, extremes and a narrow band that forces repeats
  function automatic data_t random_element();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: return VAL_MAX;
          1: return VAL_MIN;
          2: return data_t'(0);
          default: return data_t'(-1);
        endcase
      end
      1, 2: return data_t'(int'($urandom_range(0, 8)) - 4);
      default: return data_t'($urandom);
    endcase
  endfunction

  // hand one element to the driver
  task automatic queue_element(data_t v);
    element_q = {element_q, v};
    queued++;
  endtask

  task automatic push_random(int n);
    for (int i = 0; i < n; i++) queue_element(random_element());
  endtask

  // both registers in back-to-back cycles; the shadow follows each write edge
  task automatic set_dims(logic [3:0] r, logic [3:0] c);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= r;
    @(posedge clk);
    shadow_rows_cfg = r;
    cfg_index <= REG_COL_COUNT;
    cfg_data  <= c;
    @(posedge clk);
    shadow_cols_cfg = c;
    cfg_write <= 1'b0;
  endtask

  // sender stops until every transaction is in and every owed value is out
  task automatic wait_drained();
    while (element_q.size() != 0 || in_valid || sorted_q.size() != 0) @(posedge clk);
    // quiet wait before the registers may change
    repeat (10) @(posedge clk);
  endtask

  // input driver: payload only moves once the current transaction is taken
  always @(posedge clk) begin : feed
    bit slot_free;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      slot_free = !in_valid || !in_stall;
      if (in_valid && !in_stall) load_element(element_value);
      if (slot_free) begin
        if (element_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          element_value <= element_q.pop_front();
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output stall: random back-pressure, or a long hold-off when asked for
  always @(posedge clk) begin : sink
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_pct);
    end
  end

  // output monitor: each accepted transaction against the oldest owed value
  always @(posedge clk) begin : check
    matrix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (sorted_q.size() == 0) begin
        $display("%0t: unexpected output, expected none, actual value %0d last %0b",
                 $time, sorted_value, last_element);
        errors++;
      end else begin
        want = sorted_q.pop_front();
        if (sorted_value !== want.value) begin
          $display("%0t: sorted_value mismatch, expected %0d, actual %0d",
                   $time, want.value, sorted_value);
          errors++;
        end
        if (last_element !== want.last) begin
          $display("%0t: last_element mismatch, expected %0b, actual %0b",
                   $time, want.last, last_element);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [3:0] r;
    logic [3:0] c;
    int         n;
    int         phase;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset dimensions: one full 8x8 matrix before any register write,
    // at full rate with no idling on either side
    idle_pct = 0;
    push_random(STORE_DEPTH);
    wait_drained();
    idle_pct = 18;

    // 1x1: the value extremes pass straight through
    set_dims(4'd1, 4'd1);
    queue_element(VAL_MAX);
    queue_element(VAL_MIN);
    wait_drained();

    // 2x2: the main diagonal swaps its extremes, sign order not unsigned
    set_dims(4'd2, 4'd2);
    queue_element(VAL_MAX);
    queue_element(data_t'(0));
    queue_element(data_t'(-1));
    queue_element(VAL_MIN);
    wait_drained();

    // zero rows and oversize columns: a single 1x8 row
    set_dims(4'd0, 4'd9);
    push_random(8);
    wait_drained();

    // oversize rows and zero columns: a single 8x1 column
    set_dims(4'd15, 4'd0);
    push_random(8);
    wait_drained();

    // shrink while loading: five of nine in, then 2x2, the next one completes
    set_dims(4'd3, 4'd3);
    push_random(5);
    wait_drained();
    set_dims(4'd2, 4'd2);
    push_random(1);
    wait_drained();

    // random phases, drained between them so the registers change while idle
    phase = 0;
    while (queued < 160) begin
      if (phase == 0) begin
        // long receiver hold-off over three queued matrices: the input backs up
        r = 4'd3;
        c = 4'd3;
        n = 3;
        hold_req++;
      end else begin
        n = $urandom_range(1, 3);
        case ($urandom_range(0, 9))
          0: begin
            r = 4'($urandom_range(0, 15));
            c = 4'($urandom_range(0, 15));
            n = 1;
          end
          1: begin
            r = 4'($urandom_range(5, 8));
            c = 4'($urandom_range(5, 8));
            n = 1;
          end
          default: begin
            r = 4'($urandom_range(1, 4));
            c = 4'($urandom_range(1, 4));
          end
        endcase
      end
      set_dims(r, c);
      n = n * bounded_dim(r, MAX_ROWS) * bounded_dim(c, MAX_COLS);
      push_random(n);
      wait_drained();
      phase++;
    end

    // room for any stray output after the last matrix
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[matrix_diagonal_sorter_top] OK");
    end else begin
      $display("[matrix_diagonal_sorter_top] ERROR");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin : watchdog
    #5_000_000;
    $display("[matrix_diagonal_sorter_top] ERROR");
    $finish;
  end

endmodule

### filelist.f
sv/mds_pkg.sv
sv/matrix_diagonal_sorter_top.sv
tb/sv/tb_top.sv
